@@ rtl/core/abms_pkg.sv @@
package abms_pkg;

  // Bytes moved by one data word on the 64-bit bus.
  localparam int unsigned BEAT_BYTES = 64 / 8;
  localparam int unsigned BEAT_SHIFT = 3;

  // Read slots held by the back end.
  localparam int unsigned READ_SLOTS = 2;

  // Response codes.
  localparam logic [1:0] RESP_OKAY = 2'd0;
  localparam logic [1:0] RESP_ERR  = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_MEMORY_BASE = 1'b0;
  localparam logic [31:0] MEMORY_BASE_RESET = 32'h8000_0000;

  // One bus clock, as classified by the front end.
  typedef struct packed {
    logic        ar_valid;
    logic [3:0]  ar_id;
    logic [31:0] ar_addr;
    logic [8:0]  ar_beats;
    logic        aw_valid;
    logic [31:0] aw_addr;
    logic [8:0]  aw_beats;
    logic        w_valid;
    logic [63:0] w_data;
    logic [7:0]  w_strb;
    logic        w_last;
  } item_t;

  // Status of one bus clock as seen on the output side (read data travels apart).
  typedef struct packed {
    logic       ar_ready;
    logic       aw_ready;
    logic       r_valid;
    logic [3:0] r_id;
    logic [1:0] r_resp;
    logic       r_last;
    logic       r_mem;
    logic       w_ready;
    logic       b_valid;
    logic [1:0] b_resp;
    logic       perr;
  } result_t;

endpackage

@@ rtl/core/axi_burst_memory_slave_unit.sv @@
// Channel  | handshake                   | payload
// ---------+-----------------------------+---------------------------------------------
// in       | in_valid_i / in_stall_o     | ar_*, aw_*, w_* : all channels together in one word
// out      | out_valid_o / out_stall_i   | ar/aw_ready, r_*, w_ready, b_*, protocol_error
// config   | psel/penable/pwrite/pready  | memory_base at byte address 0
//
// One word per cycle while out_stall_i is low; an accepted word waits in the front queue,
// then the execute edge loads the output register and the registered RAM read together.
// Reset clears queue, burst state and output valid; memory_base returns to 0x8000_0000.
// Memory contents are not cleared; a read of a never-written word is undefined.
// An output stall holds the output register and stops execution; the front queue
// keeps taking words until its two entries are full.
module axi_burst_memory_slave_unit #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        ar_valid_i,
  input  logic [3:0]  ar_id_i,
  input  logic [31:0] ar_addr_i,
  input  logic [7:0]  ar_len_i,
  input  logic        aw_valid_i,
  input  logic [31:0] aw_addr_i,
  input  logic [7:0]  aw_len_i,
  input  logic        w_valid_i,
  input  logic [63:0] w_data_i,
  input  logic [7:0]  w_strb_i,
  input  logic        w_last_i,

  // Output words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ar_ready_o,
  output logic        aw_ready_o,
  output logic        r_valid_o,
  output logic [3:0]  r_id_o,
  output logic [63:0] r_data_o,
  output logic [1:0]  r_resp_o,
  output logic        r_last_o,
  output logic        w_ready_o,
  output logic        b_valid_o,
  output logic [1:0]  b_resp_o,
  output logic        protocol_error_o,

  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import abms_pkg::*;

  logic [31:0] memory_base_q;
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;
  result_t     res;

  // Register file: one register, every byte address decodes to it.
  assign pready = 1'b1;
  assign prdata = memory_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      memory_base_q <= MEMORY_BASE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      memory_base_q <= pwdata;
    end
  end

  // Front end: take and classify words, queue them.
  abms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ar_valid_i (ar_valid_i),
    .ar_id_i    (ar_id_i),
    .ar_addr_i  (ar_addr_i),
    .ar_len_i   (ar_len_i),
    .aw_valid_i (aw_valid_i),
    .aw_addr_i  (aw_addr_i),
    .aw_len_i   (aw_len_i),
    .w_valid_i  (w_valid_i),
    .w_data_i   (w_data_i),
    .w_strb_i   (w_strb_i),
    .w_last_i   (w_last_i),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .item_o     (q_item)
  );

  // Back end: burst state, memory access and output register.
  abms_back #(
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .memory_base_i (memory_base_q),
    .valid_i       (q_valid),
    .item_i        (q_item),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res),
    .r_data_o      (r_data_o)
  );

  assign ar_ready_o       = res.ar_ready;
  assign aw_ready_o       = res.aw_ready;
  assign r_valid_o        = res.r_valid;
  assign r_id_o           = res.r_id;
  assign r_resp_o         = res.r_resp;
  assign r_last_o         = res.r_last;
  assign w_ready_o        = res.w_ready;
  assign b_valid_o        = res.b_valid;
  assign b_resp_o         = res.b_resp;
  assign protocol_error_o = res.perr;

endmodule

@@ rtl/core/abms_ram.sv @@
module abms_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH/8-1:0]       wbe_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  localparam int unsigned NB = WIDTH / 8;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read and a write to the same entry return the old word.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NB; b++) begin
      if (we_i && wbe_i[b]) begin
        mem_q[waddr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/abms_front.sv @@
module abms_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           ar_valid_i,
  input  logic [3:0]     ar_id_i,
  input  logic [31:0]    ar_addr_i,
  input  logic [7:0]     ar_len_i,
  input  logic           aw_valid_i,
  input  logic [31:0]    aw_addr_i,
  input  logic [7:0]     aw_len_i,
  input  logic           w_valid_i,
  input  logic [63:0]    w_data_i,
  input  logic [7:0]     w_strb_i,
  input  logic           w_last_i,
  input  logic           pop_i,
  output logic           valid_o,
  output abms_pkg::item_t item_o
);

  import abms_pkg::*;

  item_t       slot_q [2];
  item_t       item_in;
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;

  // Classify: turn burst lengths into beat counts.
  always_comb begin
    item_in.ar_valid = ar_valid_i;
    item_in.ar_id    = ar_id_i;
    item_in.ar_addr  = ar_addr_i;
    item_in.ar_beats = {1'b0, ar_len_i} + 9'd1;
    item_in.aw_valid = aw_valid_i;
    item_in.aw_addr  = aw_addr_i;
    item_in.aw_beats = {1'b0, aw_len_i} + 9'd1;
    item_in.w_valid  = w_valid_i;
    item_in.w_data   = w_data_i;
    item_in.w_strb   = w_strb_i;
    item_in.w_last   = w_last_i;
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign valid_o    = (cnt_q != 2'd0);
  assign item_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ rtl/core/abms_back.sv @@
module abms_back #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [31:0]      memory_base_i,
  input  logic             valid_i,
  input  abms_pkg::item_t  item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output abms_pkg::result_t res_o,
  output logic [63:0]      r_data_o
);

  import abms_pkg::*;

  localparam int unsigned AW        = $clog2(MEM_WORDS);
  localparam logic [31:0] WIN_BYTES = 32'(MEM_WORDS * BEAT_BYTES);

  logic [8:0]  rd_left_q [READ_SLOTS];
  logic [8:0]  rd_left_d [READ_SLOTS];
  logic [31:0] rd_addr_q [READ_SLOTS];
  logic [31:0] rd_addr_d [READ_SLOTS];
  logic [3:0]  rd_id_q   [READ_SLOTS];
  logic [3:0]  rd_id_d   [READ_SLOTS];
  logic [8:0]  wr_left_q, wr_left_d;
  logic [31:0] wr_addr_q, wr_addr_d;
  logic        wr_err_q, wr_err_d;
  logic        wr_pend_q, wr_pend_d;

  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  logic        fire;
  logic        s_rd;
  logic        s_new;
  logic [31:0] rd_addr_sel;
  logic [32:0] rd_off, wr_off;
  logic        rd_win, wr_win;
  logic        ram_re, ram_we;
  logic [63:0] ram_rdata;

  // Advance only when the output register is free or drains this cycle.
  assign fire  = valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  assign s_rd        = (rd_left_q[0] == 9'd0);
  assign rd_addr_sel = s_rd ? rd_addr_q[1] : rd_addr_q[0];
  assign rd_off      = {1'b0, rd_addr_sel} - {1'b0, memory_base_i};
  assign wr_off      = {1'b0, wr_addr_q} - {1'b0, memory_base_i};
  assign rd_win      = !rd_off[32] && (rd_off[31:0] < WIN_BYTES);
  assign wr_win      = !wr_off[32] && (wr_off[31:0] < WIN_BYTES);

  always_comb begin
    rd_left_d = rd_left_q;
    rd_addr_d = rd_addr_q;
    rd_id_d   = rd_id_q;
    wr_left_d = wr_left_q;
    wr_addr_d = wr_addr_q;
    wr_err_d  = wr_err_q;
    wr_pend_d = wr_pend_q;
    res_d     = '0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    s_new     = 1'b0;
    if (fire) begin
      res_d.ar_ready = item_i.ar_valid;
      res_d.aw_ready = item_i.aw_valid;

      // Write response for the burst finished earlier.
      if (wr_pend_q) begin
        res_d.b_valid = 1'b1;
        res_d.b_resp  = wr_err_q ? RESP_ERR : RESP_OKAY;
        wr_pend_d     = 1'b0;
        wr_err_d      = 1'b0;
      end

      // One read word, slot 0 first.
      if ((s_rd ? rd_left_q[1] : rd_left_q[0]) != 9'd0) begin
        res_d.r_valid = 1'b1;
        res_d.r_id    = s_rd ? rd_id_q[1] : rd_id_q[0];
        res_d.r_last  = ((s_rd ? rd_left_q[1] : rd_left_q[0]) == 9'd1);
        if (rd_win) begin
          ram_re        = 1'b1;
          res_d.r_mem   = 1'b1;
          res_d.r_resp  = RESP_OKAY;
        end else begin
          res_d.r_resp  = RESP_ERR;
        end
        rd_left_d[s_rd] = rd_left_q[s_rd] - 9'd1;
        rd_addr_d[s_rd] = rd_addr_q[s_rd] + 32'(BEAT_BYTES);
      end

      // One write word.
      if (wr_left_q == 9'd0) begin
        if (item_i.w_valid) begin
          res_d.perr = 1'b1;
        end
      end else if (!item_i.w_valid) begin
        res_d.perr = 1'b1;
      end else begin
        res_d.w_ready = 1'b1;
        if (wr_win) begin
          ram_we = 1'b1;
        end else begin
          wr_err_d = 1'b1;
        end
        wr_addr_d = wr_addr_q + 32'(BEAT_BYTES);
        wr_left_d = wr_left_q - 9'd1;
        if ((wr_left_q == 9'd1) != item_i.w_last) begin
          res_d.perr = 1'b1;
        end
        if (wr_left_q == 9'd1) begin
          wr_pend_d = 1'b1;
        end
      end

      // New read burst: slot 0 if free after this word, else slot 1.
      if (item_i.ar_valid) begin
        s_new            = (rd_left_d[0] != 9'd0);
        rd_id_d[s_new]   = item_i.ar_id;
        rd_addr_d[s_new] = item_i.ar_addr;
        rd_left_d[s_new] = item_i.ar_beats;
      end

      // New write burst restarts any burst in flight.
      if (item_i.aw_valid) begin
        wr_left_d = item_i.aw_beats;
        wr_addr_d = item_i.aw_addr;
        if (!wr_pend_d) begin
          wr_err_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < READ_SLOTS; i++) begin
        rd_left_q[i] <= 9'd0;
        rd_addr_q[i] <= 32'd0;
        rd_id_q[i]   <= 4'd0;
      end
      wr_left_q   <= 9'd0;
      wr_addr_q   <= 32'd0;
      wr_err_q    <= 1'b0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_left_q   <= rd_left_d;
      rd_addr_q   <= rd_addr_d;
      rd_id_q     <= rd_id_d;
      wr_left_q   <= wr_left_d;
      wr_addr_q   <= wr_addr_d;
      wr_err_q    <= wr_err_d;
      wr_pend_q   <= wr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  abms_ram #(
    .WIDTH (64),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_off[AW+BEAT_SHIFT-1:BEAT_SHIFT]),
    .wbe_i   (item_i.w_strb),
    .wdata_i (item_i.w_data),
    .re_i    (ram_re),
    .raddr_i (rd_off[AW+BEAT_SHIFT-1:BEAT_SHIFT]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  // The RAM output holds while the word stalls: no read issues without fire.
  assign r_data_o    = res_q.r_mem ? ram_rdata : 64'd0;

endmodule

@@ rtl/core/abms_checker.sv @@
module abms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        r_valid_o,
  input logic [3:0]  r_id_o,
  input logic [63:0] r_data_o,
  input logic [1:0]  r_resp_o,
  input logic        r_last_o,
  input logic        b_valid_o,
  input logic [1:0]  b_resp_o
);

  import abms_pkg::*;

  // Read fields are zero in a word without read data.
  a_r_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !r_valid_o |->
      r_id_o == 4'd0 && r_data_o == 64'd0 && r_resp_o == RESP_OKAY && !r_last_o)
    else $error("read fields not zero without read data");

  // An address error returns zero data.
  a_r_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && r_valid_o && r_resp_o == RESP_ERR |-> r_data_o == 64'd0)
    else $error("read error with nonzero data");

  // No write response code without a write response.
  a_b_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !b_valid_o |-> b_resp_o == RESP_OKAY)
    else $error("write response code without response");

  // A stalled word holds, read data from memory included.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(r_data_o) && $stable(r_id_o) && $stable(b_valid_o))
    else $error("stalled output word changed");

endmodule

bind axi_burst_memory_slave_unit abms_checker u_abms_checker (.*);
